// File: rtl/pscq_pkg.sv
package pscq_pkg;

  // Number of pads with their own history; pad indexes at or above it are ignored.
  localparam int PAD_COUNT       = 4;
  localparam int PAD_W           = 2;
  localparam int PAD_SLOTS       = 1 << PAD_W;
  localparam int LEFT_CLICK_BIT  = 6;
  localparam int RIGHT_CLICK_BIT = 7;

  localparam int LEVEL_W = 16;
  localparam int BTN_W   = 16;
  localparam int AXIS_W  = 16;
  localparam int DIR_W   = 4;

  // Configuration register indexes.
  localparam logic [1:0] REG_ARM      = 2'd0;
  localparam logic [1:0] REG_RELEASE  = 2'd1;
  localparam logic [1:0] REG_DOMINATE = 2'd2;

  localparam logic [LEVEL_W-1:0] ARM_RESET      = 16'd16000;
  localparam logic [LEVEL_W-1:0] RELEASE_RESET  = 16'd10000;
  localparam logic [LEVEL_W-1:0] DOMINATE_RESET = 16'd8000;

  // Direction bit positions.
  localparam int STICK_UP    = 0;
  localparam int STICK_DOWN  = 1;
  localparam int STICK_LEFT  = 2;
  localparam int STICK_RIGHT = 3;

  localparam logic [BTN_W-1:0] THUMB_BITS =
    (BTN_W'(1) << LEFT_CLICK_BIT) | (BTN_W'(1) << RIGHT_CLICK_BIT);

  typedef struct packed {
    logic [LEVEL_W-1:0] arm;
    logic [LEVEL_W-1:0] release_lvl;
    logic [LEVEL_W-1:0] margin;
  } stick_cfg_t;

  // Per-pad chord resolver history; thumb bit 0 is left, bit 1 is right.
  typedef struct packed {
    logic [1:0] last_thumbs;
    logic [1:0] menu_owned;
    logic       both_seen;
    logic       chord_done;
  } thumb_state_t;

  typedef struct packed {
    logic chord;
    logic left;
    logic right;
  } toggles_t;

endpackage

// File: rtl/pscq_stick.sv
module pscq_stick
  import pscq_pkg::*;
(
  input  logic signed [AXIS_W-1:0] stick_x,
  input  logic signed [AXIS_W-1:0] stick_y,
  input  logic        [DIR_W-1:0]  prev_dirs,
  input  stick_cfg_t               cfg,
  output logic        [DIR_W-1:0]  dirs
);

  logic [AXIS_W:0]   ax;
  logic [AXIS_W:0]   ay;
  logic [AXIS_W:0]   v_thr;
  logic [AXIS_W:0]   h_thr;
  logic [AXIS_W+1:0] ay_plus;
  logic [AXIS_W+1:0] ax_plus;
  logic              v_on;
  logic              h_on;

  always_comb begin
    ax = stick_x[AXIS_W-1] ? (AXIS_W+1)'(-$signed({stick_x[AXIS_W-1], stick_x}))
                           : {1'b0, stick_x};
    ay = stick_y[AXIS_W-1] ? (AXIS_W+1)'(-$signed({stick_y[AXIS_W-1], stick_y}))
                           : {1'b0, stick_y};
    // A held axis only needs the lower release level to stay on.
    v_thr = {1'b0, ((prev_dirs[STICK_UP] | prev_dirs[STICK_DOWN]) ? cfg.release_lvl : cfg.arm)};
    h_thr = {1'b0, ((prev_dirs[STICK_LEFT] | prev_dirs[STICK_RIGHT]) ? cfg.release_lvl
                                                                     : cfg.arm)};
    // |y| > |x| - margin, rearranged so that nothing goes negative.
    ay_plus = {1'b0, ay} + {2'b00, cfg.margin};
    ax_plus = {1'b0, ax} + {2'b00, cfg.margin};
    v_on = (ay >= v_thr) && (ay_plus > {1'b0, ax});
    h_on = (ax >= h_thr) && (ax_plus > {1'b0, ay});
    dirs = '0;
    dirs[STICK_UP]    = v_on && (stick_y > 0);
    dirs[STICK_DOWN]  = v_on && !(stick_y > 0);
    dirs[STICK_RIGHT] = h_on && (stick_x > 0);
    dirs[STICK_LEFT]  = h_on && !(stick_x > 0);
  end

endmodule

// File: rtl/pscq_thumb.sv
module pscq_thumb
  import pscq_pkg::*;
(
  input  logic [1:0]   thumbs,
  input  logic         prompt_open,
  input  logic         menu_active,
  input  thumb_state_t st,
  output thumb_state_t st_next,
  output toggles_t     toggles
);

  logic [1:0] owned;
  logic [1:0] released;
  logic [1:0] falling;
  logic       both;
  logic       done;

  always_comb begin
    both     = st.both_seen | (thumbs[0] & thumbs[1]);
    owned    = menu_active ? (st.menu_owned | thumbs) : st.menu_owned;
    released = st.last_thumbs & ~thumbs;
    done     = st.chord_done | (|(released & owned));
    falling  = released & ~owned;
    toggles  = '0;

    // Clicks resolve on their release: a chord fires once, lone clicks fire per side.
    if (|falling) begin
      if (both) begin
        if (!done) begin
          done          = 1'b1;
          toggles.chord = 1'b1;
        end
      end else begin
        toggles.left  = falling[0];
        toggles.right = falling[1];
      end
    end
    if (thumbs == 2'b00) begin
      both = 1'b0;
      done = 1'b0;
    end

    st_next.last_thumbs = thumbs;
    st_next.menu_owned  = owned & thumbs;
    st_next.both_seen   = both;
    st_next.chord_done  = done;

    // A text prompt takes the thumbs over without firing anything.
    if (prompt_open) begin
      toggles             = '0;
      st_next.menu_owned  = st.menu_owned;
      st_next.both_seen   = 1'b0;
      st_next.chord_done  = 1'b0;
    end
  end

endmodule

// File: rtl/pad_stick_and_chord_qualifier.sv
// Gamepad poll qualifier. One input transaction on the s_ channel carries one
// poll of one pad; exactly one result transaction leaves on the m_ channel for
// every poll, in order. The result holds button press edges, the four stick
// directions with their rising edges, thumb-click chord and single toggles and
// the mask of held thumb-click bits. Polls without focus, or for a pad index at
// or above the pad count, give a result that is all zero and leave history alone.
//
// The user must write thresholds through cfg_we / cfg_index / cfg_data only
// while idle; the block does not enforce it. An accepted poll lands in an
// input register; from there the quantizer and chord logic update that pad's
// history and load the result register. A poll can be accepted every cycle
// while the result side is not stalled, also for the same pad twice in a row,
// since the history write and the result load happen at the same edge.
//
// Reset (rst, synchronous) clears all pad history, both valid flags and loads
// the default thresholds. When the receiver stalls, the result register holds;
// the input register still takes one more poll if it is empty, and s_tready
// then drops until the result is taken.
module pad_stick_and_chord_qualifier
  import pscq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pad_index[1:0], button_bits[17:2], stick_x[33:18], stick_y[49:34],
  // in_focus[50], prompt_open[51], menu_active[52], zero fill [55:53]
  input  logic [55:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // accepted[0], press_edges[16:1], direction_levels[20:17],
  // direction_edges[24:21], chord_toggle[25], left_toggle[26],
  // right_toggle[27], thumb_mask[43:28], zero fill [47:44]
  output logic [47:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam logic [PAD_W:0] PAD_LIMIT = (PAD_W+1)'(PAD_COUNT);

  // Thresholds.
  stick_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arm         <= ARM_RESET;
      cfg.release_lvl <= RELEASE_RESET;
      cfg.margin      <= DOMINATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ARM:      cfg.arm         <= cfg_data;
        REG_RELEASE:  cfg.release_lvl <= cfg_data;
        REG_DOMINATE: cfg.margin      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  logic                     in_v;
  logic [PAD_W-1:0]         q_pad;
  logic [BTN_W-1:0]         q_buttons;
  logic signed [AXIS_W-1:0] q_x;
  logic signed [AXIS_W-1:0] q_y;
  logic                     q_focus;
  logic                     q_prompt;
  logic                     q_menu;
  logic                     advance;

  assign advance  = in_v && (!m_tvalid || m_tready);
  assign s_tready = !in_v || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      q_pad     <= s_tdata[1:0];
      q_buttons <= s_tdata[17:2];
      q_x       <= s_tdata[33:18];
      q_y       <= s_tdata[49:34];
      q_focus   <= s_tdata[50];
      q_prompt  <= s_tdata[51];
      q_menu    <= s_tdata[52];
    end
  end

  // Per-pad history.
  logic [BTN_W-1:0] last_buttons [PAD_SLOTS];
  logic [DIR_W-1:0] last_dirs    [PAD_SLOTS];
  thumb_state_t     thumb_st     [PAD_SLOTS];

  logic             pad_ok;
  logic [DIR_W-1:0] dirs;
  thumb_state_t     thumb_next;
  toggles_t         toggles;
  logic [1:0]       thumbs;

  assign pad_ok = q_focus && ({1'b0, q_pad} < PAD_LIMIT);
  assign thumbs = {q_buttons[RIGHT_CLICK_BIT], q_buttons[LEFT_CLICK_BIT]};

  pscq_stick u_stick (
    .stick_x   (q_x),
    .stick_y   (q_y),
    .prev_dirs (last_dirs[q_pad]),
    .cfg       (cfg),
    .dirs      (dirs)
  );

  pscq_thumb u_thumb (
    .thumbs      (thumbs),
    .prompt_open (q_prompt),
    .menu_active (q_menu),
    .st          (thumb_st[q_pad]),
    .st_next     (thumb_next),
    .toggles     (toggles)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAD_SLOTS; i++) begin
        last_buttons[i] <= '0;
        last_dirs[i]    <= '0;
        thumb_st[i]     <= '0;
      end
    end else if (advance && pad_ok) begin
      last_buttons[q_pad] <= q_buttons;
      last_dirs[q_pad]    <= dirs;
      thumb_st[q_pad]     <= thumb_next;
    end
  end

  // Result register.
  logic             r_accepted;
  logic [BTN_W-1:0] r_press;
  logic [DIR_W-1:0] r_levels;
  logic [DIR_W-1:0] r_edges;
  toggles_t         r_toggles;
  logic [BTN_W-1:0] r_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (pad_ok) begin
        r_accepted <= 1'b1;
        r_press    <= q_buttons & ~last_buttons[q_pad];
        r_levels   <= dirs;
        r_edges    <= dirs & ~last_dirs[q_pad];
        r_toggles  <= toggles;
        r_mask     <= q_prompt ? '0 : (q_buttons & THUMB_BITS);
      end else begin
        r_accepted <= 1'b0;
        r_press    <= '0;
        r_levels   <= '0;
        r_edges    <= '0;
        r_toggles  <= '0;
        r_mask     <= '0;
      end
    end
  end

  assign m_tdata = {4'b0000, r_mask, r_toggles.right, r_toggles.left, r_toggles.chord,
                    r_edges, r_levels, r_press, r_accepted};

  // A chord toggle never comes together with a single-click toggle.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(r_toggles.chord && (r_toggles.left || r_toggles.right)))
    else $error("chord toggle together with a single toggle");

  // Up and down are exclusive, as are left and right.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(r_levels[STICK_UP] && r_levels[STICK_DOWN]) &&
                 !(r_levels[STICK_LEFT] && r_levels[STICK_RIGHT]))
    else $error("opposite directions active at once");

  // A new direction is always an active one.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((r_edges & ~r_levels) == '0))
    else $error("direction edge without direction level");

  // An ignored poll reports nothing else.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !r_accepted) |-> (m_tdata == '0))
    else $error("ignored poll carries data");

  // The input side only stalls behind a full, stalled result register.
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready && in_v))
    else $error("input stalled while result side is free");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the gamepad poll qualifier. Every accepted poll is
// run through a behavioral copy of the per-pad history (button edges, stick
// quantizer with hysteresis and dominance, thumb-click chord resolver), and the
// predicted report is queued. Reports leaving the block are compared in order,
// field by field, against that queue.
module testbench;
  import pscq_pkg::*;

  localparam int RANDOM_PER_PHASE = 100;
  localparam int PHASES           = 6;
  localparam int HOLD_OFF_CYCLES  = 60;

  // One poll as it travels on s_tdata; the first member sits in the top bits.
  typedef struct packed {
    logic        menu;
    logic        prompt;
    logic        focus;
    logic [15:0] stick_y;
    logic [15:0] stick_x;
    logic [15:0] buttons;
    logic [1:0]  pad;
  } poll_t;

  // One report as it travels on m_tdata[43:0].
  typedef struct packed {
    logic [15:0] thumb_mask;
    logic        right_toggle;
    logic        left_toggle;
    logic        chord_toggle;
    logic [3:0]  dir_edges;
    logic [3:0]  dir_levels;
    logic [15:0] press_edges;
    logic        accepted;
  } report_t;

  // A directed row: the poll, and where the answer is obvious, the report.
  typedef struct {
    bit [1:0]  pad;
    bit [15:0] buttons;
    bit [15:0] x;
    bit [15:0] y;
    bit        focus;
    bit        prompt;
    bit        menu;
    bit        typed;
    bit        acc;
    bit [15:0] press;
    bit [3:0]  dl;
    bit [3:0]  de;
    bit        ch;
    bit        lt;
    bit        rt;
    bit [15:0] mask;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // pad_index[1:0], button_bits[17:2], stick_x[33:18], stick_y[49:34],
  // in_focus[50], prompt_open[51], menu_active[52], zero fill [55:53]
  logic [55:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // accepted[0], press_edges[16:1], direction_levels[20:17],
  // direction_edges[24:21], chord_toggle[25], left_toggle[26],
  // right_toggle[27], thumb_mask[43:28], zero fill [47:44]
  logic [47:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_ARM;
  logic [15:0] cfg_data = '0;

  pad_stick_and_chord_qualifier u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the thresholds and of every pad's history.
  logic [15:0] arm_lvl    = ARM_RESET;
  logic [15:0] rel_lvl    = RELEASE_RESET;
  logic [15:0] dom_margin = DOMINATE_RESET;

  logic [15:0] pad_buttons    [PAD_SLOTS];
  logic [3:0]  pad_dirs       [PAD_SLOTS];
  logic        pad_both_seen  [PAD_SLOTS];
  logic        pad_chord_done [PAD_SLOTS];
  logic [1:0]  pad_thumbs     [PAD_SLOTS];
  logic [1:0]  pad_menu_owned [PAD_SLOTS];

  report_t predicted_reports [$];
  int      mismatches = 0;

  // Stimulus-side view of the thumbs, used to walk them through press and
  // release sequences per pad.
  logic [1:0] walk_thumbs [PAD_SLOTS];
  logic [1:0] last_pad = '0;

  // Traffic shaping; no_idle is shared by the sender and the receiver.
  logic no_idle  = 1'b0;
  logic hold_req = 1'b0;
  int   hold_left = 0;
  bit   hold_taken = 1'b0;

  // Directed polls. Column order: pad, buttons, x, y, focus, prompt, menu,
  // typed, then the typed report: accepted, press edges, direction levels,
  // direction edges, chord, left, right, thumb mask.
  plan_row_t directed_plan [24] = '{
    // Ignored poll with prompt, menu and every button set gives an all-zero report.
    '{0, 'hFFFF, 'h8000, 'h7FFF, 0, 1, 1, 1, 0, 'h0000, 0, 0, 0, 0, 0, 'h0000},
    // First poll after reset: every button is a new press, both thumbs held.
    '{0, 'hFFFF, 'h0000, 'h0000, 1, 0, 0, 1, 1, 'hFFFF, 0, 0, 0, 0, 0, 'h00C0},
    // Both thumbs released together resolve as one chord.
    '{0, 'h0000, 'h0000, 'h0000, 1, 0, 0, 1, 1, 'h0000, 0, 0, 1, 0, 0, 'h0000},
    // Full up, then full down on a held vertical axis.
    '{1, 'h0000, 'h0000, 'h7FFF, 1, 0, 0, 1, 1, 'h0000, 1, 1, 0, 0, 0, 'h0000},
    '{1, 'h0000, 'h0000, 'h8000, 1, 0, 0, 1, 1, 'h0000, 2, 2, 0, 0, 0, 'h0000},
    // Both axes at their extremes at once.
    '{1, 'h0000, 'h7FFF, 'h8000, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // Held horizontal axis stays on between release and arm levels.
    '{1, 'h0000, 'h2EE0, 'h0000, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // Same magnitude on a pad with nothing held does not arm.
    '{2, 'h0000, 'h2EE0, 'h0000, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{2, 'h0000, 'hB1E0, 'h3A98, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // Vertical is past arm but loses on dominance to the horizontal axis.
    '{3, 'h0000, 'h7530, 'h4268, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // Lone left click, then lone right click.
    '{0, 'h0040, 'h0000, 'h0000, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 'h0000, 'h0000, 'h0000, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 'h0080, 'h0000, 'h0000, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 'h0000, 'h0000, 'h0000, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // Chord released one thumb at a time fires only on the first release.
    '{0, 'h00C0, 'h0000, 'h0000, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 'h0080, 'h0000, 'h0000, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 'h0000, 'h0000, 'h0000, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // Click pressed under the open menu is owned and its release is silent.
    '{1, 'h0040, 'h0000, 'h0000, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, 'h0000, 'h0000, 'h0000, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // Thumbs pressed under a prompt, released after it closes.
    '{2, 'h00C0, 'h0000, 'h0000, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{2, 'h0000, 'h0000, 'h0000, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{3, 'hFFFF, 'hFFFF, 'hFFFF, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{3, 'h5A5A, 'h0001, 'h8001, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // Unfocused poll in mid stream leaves history alone.
    '{2, 'h0000, 'h8000, 'h8000, 0, 0, 0, 1, 0, 'h0000, 0, 0, 0, 0, 0, 'h0000}
  };

  initial begin
    for (int i = 0; i < PAD_SLOTS; i++) begin
      pad_buttons[i]    = '0;
      pad_dirs[i]       = '0;
      pad_both_seen[i]  = 1'b0;
      pad_chord_done[i] = 1'b0;
      pad_thumbs[i]     = '0;
      pad_menu_owned[i] = '0;
      walk_thumbs[i]    = '0;
    end
  end

  // Works out the report for one poll and advances that pad's history.
  function automatic report_t qualify_poll(poll_t p);
    report_t    r;
    int         xs, ys, ax, ay, arm, rel, dom;
    logic [3:0] prev, dirs;
    logic [1:0] thumbs, released, falling;
    r = '0;
    if (!p.focus || int'(p.pad) >= PAD_COUNT) return r;
    r.accepted = 1'b1;

    r.press_edges = p.buttons & ~pad_buttons[p.pad];
    pad_buttons[p.pad] = p.buttons;

    // A held axis only has to stay above the release level; a fresh one has to
    // reach the arm level. Either way it must not be swamped by the other axis.
    xs   = int'($signed(p.stick_x));
    ys   = int'($signed(p.stick_y));
    ax   = (xs < 0) ? -xs : xs;
    ay   = (ys < 0) ? -ys : ys;
    arm  = int'(arm_lvl);
    rel  = int'(rel_lvl);
    dom  = int'(dom_margin);
    prev = pad_dirs[p.pad];
    dirs = '0;
    if (ay >= ((prev[STICK_UP] || prev[STICK_DOWN]) ? rel : arm) && ay > ax - dom)
      dirs[(ys > 0) ? STICK_UP : STICK_DOWN] = 1'b1;
    if (ax >= ((prev[STICK_LEFT] || prev[STICK_RIGHT]) ? rel : arm) && ax > ay - dom)
      dirs[(xs > 0) ? STICK_RIGHT : STICK_LEFT] = 1'b1;
    r.dir_levels = dirs;
    r.dir_edges  = dirs & ~prev;
    pad_dirs[p.pad] = dirs;

    thumbs = {p.buttons[RIGHT_CLICK_BIT], p.buttons[LEFT_CLICK_BIT]};
    if (p.prompt) begin
      // The prompt swallows the clicks but still tracks their levels.
      pad_thumbs[p.pad]     = thumbs;
      pad_both_seen[p.pad]  = 1'b0;
      pad_chord_done[p.pad] = 1'b0;
      return r;
    end

    if (&thumbs) pad_both_seen[p.pad] = 1'b1;
    if (p.menu) pad_menu_owned[p.pad] |= thumbs;
    released = pad_thumbs[p.pad] & ~thumbs;
    if (|(released & pad_menu_owned[p.pad])) pad_chord_done[p.pad] = 1'b1;
    falling = released & ~pad_menu_owned[p.pad];
    pad_menu_owned[p.pad] &= thumbs;

    if (|falling) begin
      if (pad_both_seen[p.pad]) begin
        if (!pad_chord_done[p.pad]) begin
          pad_chord_done[p.pad] = 1'b1;
          r.chord_toggle = 1'b1;
        end
      end else begin
        r.left_toggle  = falling[0];
        r.right_toggle = falling[1];
      end
    end
    if (thumbs == 2'b00) begin
      pad_both_seen[p.pad]  = 1'b0;
      pad_chord_done[p.pad] = 1'b0;
    end
    pad_thumbs[p.pad] = thumbs;
    r.thumb_mask = p.buttons & THUMB_BITS;
    return r;
  endfunction

  // Stick values that favor the interesting magnitudes for the current levels.
  function automatic logic [15:0] pick_axis();
    int m;
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      2: m = int'(arm_lvl) + int'($urandom_range(0, 4)) - 2;
      3: m = int'(rel_lvl) + int'($urandom_range(0, 4)) - 2;
      4: m = int'($urandom_range(0, 3000));
      default: m = int'(dom_margin) + int'($urandom_range(0, 8000));
    endcase
    if (m < 0) m = 0;
    if (m >= 32768) return 16'h8000;
    return $urandom_range(0, 1) ? 16'(-m) : 16'(m);
  endfunction

  // Random poll: the same pad at least half of the time, thumbs mostly walked one
  // press or release at a time so that chords and lone clicks resolve often.
  function automatic poll_t next_poll();
    poll_t      p;
    logic [1:0] t;
    int         k;
    p.pad = $urandom_range(0, 1) ? last_pad : 2'($urandom_range(0, 3));
    last_pad = p.pad;
    t = walk_thumbs[p.pad];
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        k    = int'($urandom_range(0, 1));
        t[k] = ~t[k];
      end
      6, 7: ;
      default: t = 2'($urandom);
    endcase
    walk_thumbs[p.pad] = t;
    if ($urandom_range(0, 4) == 0) begin
      p.buttons = 16'($urandom);
    end else begin
      p.buttons = 16'($urandom) & ~THUMB_BITS;
      p.buttons[LEFT_CLICK_BIT]  = t[0];
      p.buttons[RIGHT_CLICK_BIT] = t[1];
    end
    p.stick_x = pick_axis();
    p.stick_y = pick_axis();
    p.focus   = $urandom_range(0, 9) != 0;
    p.prompt  = $urandom_range(0, 9) == 0;
    p.menu    = $urandom_range(0, 6) == 0;
    return p;
  endfunction

  // Offers one poll and returns at the edge where the transaction completes.
  // s_tvalid is left high so a back-to-back poll never drops it in between.
  task automatic send_poll(poll_t p);
    while (!no_idle && $urandom_range(0, 99) < 33) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, p};
    do @(posedge clk); while (!s_tready);
  endtask

  // Writes all three thresholds in consecutive cycles while the block is idle.
  task automatic load_levels(logic [15:0] arm, logic [15:0] rel, logic [15:0] dom);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ARM;
    cfg_data  <= arm;
    @(posedge clk);
    cfg_index <= REG_RELEASE;
    cfg_data  <= rel;
    @(posedge clk);
    cfg_index <= REG_DOMINATE;
    cfg_data  <= dom;
    @(posedge clk);
    cfg_we     <= 1'b0;
    arm_lvl    = arm;
    rel_lvl    = rel;
    dom_margin = dom;
  endtask

  // Stops offering, waits until every predicted report has come back and then
  // idles on to cover the two-stage pipeline.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (predicted_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic compare_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Receiver: checks every completed result transaction and drives m_tready.
  // It idles at random, runs without idling when asked, and once holds off for
  // a long stretch so the pipeline fills and the block stalls its input.
  always @(posedge clk) begin : sink
    report_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = report_t'(m_tdata[43:0]);
      if (predicted_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none actual %h", $time, got);
        mismatches++;
      end else begin
        want = predicted_reports.pop_front();
        compare_field("accepted", want.accepted, got.accepted);
        compare_field("press_edges", want.press_edges, got.press_edges);
        compare_field("direction_levels", want.dir_levels, got.dir_levels);
        compare_field("direction_edges", want.dir_edges, got.dir_edges);
        compare_field("chord_toggle", want.chord_toggle, got.chord_toggle);
        compare_field("left_toggle", want.left_toggle, got.left_toggle);
        compare_field("right_toggle", want.right_toggle, got.right_toggle);
        compare_field("thumb_mask", want.thumb_mask, got.thumb_mask);
      end
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_OFF_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= no_idle || ($urandom_range(0, 99) >= 33);
    end
  end

  initial begin
    poll_t      p;
    report_t    want;
    logic [15:0] a;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      p.pad     = directed_plan[i].pad;
      p.buttons = directed_plan[i].buttons;
      p.stick_x = directed_plan[i].x;
      p.stick_y = directed_plan[i].y;
      p.focus   = directed_plan[i].focus;
      p.prompt  = directed_plan[i].prompt;
      p.menu    = directed_plan[i].menu;
      send_poll(p);
      want = qualify_poll(p);
      if (directed_plan[i].typed) begin
        want.accepted     = directed_plan[i].acc;
        want.press_edges  = directed_plan[i].press;
        want.dir_levels   = directed_plan[i].dl;
        want.dir_edges    = directed_plan[i].de;
        want.chord_toggle = directed_plan[i].ch;
        want.left_toggle  = directed_plan[i].lt;
        want.right_toggle = directed_plan[i].rt;
        want.thumb_mask   = directed_plan[i].mask;
      end
      predicted_reports.push_back(want);
    end
    drain();

    // Phase 0 keeps the reset thresholds; the others walk through both
    // extremes, a wide hysteresis band and random settings.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        1: load_levels(16'd0, 16'd0, 16'd0);
        2: load_levels(16'h8000, 16'h8000, 16'h8000);
        3: load_levels(16'd20000, 16'd5000, 16'd0);
        4: begin
          a = 16'($urandom_range(4000, 32768));
          load_levels(a, 16'($urandom_range(0, a)), 16'($urandom_range(0, 32768)));
        end
        5: load_levels(16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
                       16'($urandom_range(0, 32768)));
        default: ;
      endcase
      // One phase runs at full rate on both sides; the next one carries the
      // long receiver hold-off.
      if (phase == 3) no_idle <= 1'b1;
      if (phase == 4) begin
        no_idle  <= 1'b0;
        hold_req <= 1'b1;
      end
      repeat (RANDOM_PER_PHASE) begin
        p = next_poll();
        send_poll(p);
        predicted_reports.push_back(qualify_poll(p));
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (predicted_reports.size() != 0) begin
      $display("%0t: reports missing, expected %0d more actual 0", $time,
               predicted_reports.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: sim.f
rtl/pscq_pkg.sv
rtl/pscq_stick.sv
rtl/pscq_thumb.sv
rtl/pad_stick_and_chord_qualifier.sv
sim/testbench.sv
